// File: hw/rtl/psfp_pkg.sv
// Package for the particulate sensor frame parser.
// Holds the frame layout constants and the result record type.
// No dependencies; every module of the parser imports it.
package psfp_pkg;

  // Header bytes and frame layout
  localparam logic [7:0] HDR_FIRST    = 8'h42;
  localparam logic [7:0] HDR_SECOND   = 8'h4D;
  localparam int unsigned POS_W       = 5;
  localparam logic [POS_W-1:0] POS_HUNT   = 5'd0;
  localparam logic [POS_W-1:0] POS_HDR2   = 5'd1;
  localparam logic [POS_W-1:0] POS_BODY   = 5'd2;
  localparam logic [POS_W-1:0] POS_SUMEND = 5'd30;
  localparam logic [POS_W-1:0] POS_LAST   = 5'd31;
  localparam logic [POS_W-1:0] MASS_OFF_STD = 5'd4;
  localparam logic [POS_W-1:0] MASS_OFF_ATM = 5'd10;
  localparam logic [POS_W-1:0] COUNT_OFF    = 5'd16;

  // Captured words: three mass words, then six count words
  localparam int unsigned NUM_MASS  = 3;
  localparam int unsigned NUM_WORDS = 9;
  localparam int unsigned WORD_W    = 16;

  // Configuration register indexes
  localparam logic REG_ATM_SEL = 1'b0;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic                        checksum_ok;
    logic [NUM_WORDS*WORD_W-1:0] words;   // word 0 in the low bits
  } result_t;

endpackage

// File: hw/rtl/particulate_sensor_frame_parser_top.sv
// Top level of the particulate sensor frame parser.
// Holds the configuration register, the frame tracker and the output stage.
// Depends on psfp_pkg, psfp_frame and psfp_out_skid.
//
//   channel | direction | payload
//   in_     | stream in | tdata[7:0] rx_byte
//   out_    | stream out| tdata: nine 16-bit words, tuser: checksum_ok
//   cfg_    | APB slave | reg 0 at 0x0: atmospheric_select (bit 0)
//
// Each byte is taken in one cycle; a new byte may be taken every cycle.
// A result is registered into the output register from the last frame byte, or parked in the skid stage on a stall.
// The skid stage lets one more result queue; input stalls only when it is full.
// Reset is synchronous: header hunt restarts, atmospheric_select returns to 1.
module particulate_sensor_frame_parser_top (
  input  logic         clk,
  input  logic         rst_n,
  // Byte stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,     // [7:0] rx_byte
  // Result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,    // pm1_mass, pm2_5_mass, pm10_mass, count_0_3um,
                                     // count_0_5um, count_1_0um, count_2_5um,
                                     // count_5_0um, count_10um (16 bits each, low first)
  output logic [0:0]   out_tuser,    // [0] checksum_ok
  // Configuration
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import psfp_pkg::*;

  logic    atm_sel_r;
  logic    byte_valid;
  logic    res_valid;
  result_t res;
  result_t out_res;
  logic    cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Configuration register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atm_sel_r <= 1'b1;
    end else if (cfg_wr && cfg_paddr[2] == REG_ATM_SEL) begin
      atm_sel_r <= cfg_pwdata[0];
    end
  end

  // Register read-back
  assign cfg_prdata = (cfg_paddr[2] == REG_ATM_SEL) ? {31'd0, atm_sel_r} : 32'd0;

  assign byte_valid = in_tvalid && in_tready;

  psfp_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .rx_byte    (in_tdata),
    .atm_sel    (atm_sel_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  psfp_out_skid u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (res_valid),
    .push_data  (res),
    .push_ready (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_res)
  );

  assign out_tdata = out_res.words;
  assign out_tuser = out_res.checksum_ok;

endmodule

// File: hw/rtl/psfp_frame.sv
// Frame tracker for the particulate sensor frame parser.
// Hunts the header, counts frame bytes, sums and captures words per byte.
// Depends on psfp_pkg.
module psfp_frame (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_valid,
  input  logic [7:0]        rx_byte,
  input  logic              atm_sel,
  output logic              res_valid,
  output psfp_pkg::result_t res
);
  import psfp_pkg::*;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [WORD_W-1:0] sum_r, sum_nxt;
  logic [7:0]        hold_r, hold_nxt;
  word_t             words_r [NUM_WORDS];

  logic [POS_W-1:0]  off;
  logic [POS_W-1:0]  base;
  word_t             word;
  logic [NUM_WORDS-1:0] word_we;
  logic [WORD_W-1:0] sum_add;

  assign word    = {hold_r, rx_byte};
  assign off     = pos_r - 5'd1;
  assign base    = atm_sel ? MASS_OFF_ATM : MASS_OFF_STD;
  assign sum_add = sum_r + {8'd0, rx_byte};

  // Next position, sum and held high byte
  always_comb begin
    pos_nxt  = pos_r;
    sum_nxt  = sum_r;
    hold_nxt = hold_r;
    if (pos_r == POS_HUNT) begin
      if (rx_byte == HDR_FIRST) begin
        sum_nxt = {8'd0, rx_byte};
        pos_nxt = POS_HDR2;
      end
    end else if (pos_r == POS_HDR2) begin
      if (rx_byte == HDR_SECOND) begin
        sum_nxt = sum_add;
        pos_nxt = POS_BODY;
      end else if (rx_byte == HDR_FIRST) begin
        sum_nxt = {8'd0, rx_byte};
      end else begin
        pos_nxt = POS_HUNT;
      end
    end else begin
      if (pos_r < POS_SUMEND) sum_nxt = sum_add;
      if (!pos_r[0]) begin
        hold_nxt = rx_byte;
        pos_nxt  = pos_r + 5'd1;
      end else if (pos_r == POS_LAST) begin
        pos_nxt = POS_HUNT;
      end else begin
        pos_nxt = pos_r + 5'd1;
      end
    end
  end

  // Select the capture slot for a completed word
  always_comb begin
    for (int k = 0; k < NUM_WORDS; k++) begin
      if (k < NUM_MASS) begin
        word_we[k] = (off == base + POS_W'(2 * k));
      end else begin
        word_we[k] = (off == COUNT_OFF + POS_W'(2 * (k - NUM_MASS)));
      end
    end
    if (!(byte_valid && pos_r >= POS_BODY && pos_r[0] && pos_r != POS_LAST)) begin
      word_we = '0;
    end
  end

  // Advance control state on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_HUNT;
      sum_r  <= '0;
      hold_r <= '0;
    end else if (byte_valid) begin
      pos_r  <= pos_nxt;
      sum_r  <= sum_nxt;
      hold_r <= hold_nxt;
    end
  end

  // Capture words
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_WORDS; k++) begin
      if (word_we[k]) words_r[k] <= word;
    end
  end

  // Report at the checksum word
  assign res_valid = byte_valid && (pos_r == POS_LAST);
  always_comb begin
    res.checksum_ok = (word == sum_r);
    for (int k = 0; k < NUM_WORDS; k++) begin
      res.words[k*WORD_W +: WORD_W] = words_r[k];
    end
  end

endmodule

// File: hw/rtl/psfp_out_skid.sv
// Result output register with a skid stage for the frame parser.
// Keeps the input side open while a result waits to be taken.
// Depends on psfp_pkg.
module psfp_out_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  psfp_pkg::result_t push_data,
  output logic              push_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output psfp_pkg::result_t out_data
);
  import psfp_pkg::*;

  logic    out_valid_r;
  logic    skid_valid_r;
  result_t out_data_r;
  result_t skid_data_r;
  logic    stall;

  assign stall      = out_valid_r && !out_ready;
  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (stall) begin
      if (push_valid) skid_valid_r <= 1'b1;
    end else begin
      out_valid_r  <= skid_valid_r || push_valid;
      skid_valid_r <= 1'b0;
    end
  end

  // Payload: park in skid on stall, else refill the output register
  always_ff @(posedge clk) begin
    if (stall) begin
      if (push_valid && !skid_valid_r) skid_data_r <= push_data;
    end else if (skid_valid_r) begin
      out_data_r <= skid_data_r;
    end else if (push_valid) begin
      out_data_r <= push_data;
    end
  end

endmodule
